// ===== hw/rtl/dnv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number validator package
// Shared character classes, the beat format of the internal queue and the
// queue status bundle.
// ----------------------------------------------------------------------------
package dnv_pkg;

  // Default depth of the queue between the classifier and the parser.
  localparam int unsigned QueueDepth = 4;

  // Each byte is reduced to one of these classes before it is queued.
  typedef enum logic [2:0] {
    ClsSpace,
    ClsSign,
    ClsDigit,
    ClsPoint,
    ClsExpMark,
    ClsOther
  } sym_class_e;

  // One queued beat: the class of the byte and the end-of-string mark.
  typedef struct packed {
    sym_class_e cls;
    logic       eos;
  } dnv_beat_t;

  // Queue status as seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } dnv_qstat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dnv_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number validator front end
// Reduces each incoming byte to a character class and forms the queue beat.
// ----------------------------------------------------------------------------
module dnv_front import dnv_pkg::*; (
  input  logic [7:0] symbol_i,
  input  logic       end_of_string_i,
  output dnv_beat_t  beat_o
);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChExp   = 8'h65;

  sym_class_e cls;

  // Only lowercase e marks an exponent; everything not listed is invalid.
  always_comb begin
    priority if (symbol_i >= ChZero && symbol_i <= ChNine) begin
      cls = ClsDigit;
    end else if (symbol_i == ChSpace) begin
      cls = ClsSpace;
    end else if (symbol_i == ChPlus || symbol_i == ChMinus) begin
      cls = ClsSign;
    end else if (symbol_i == ChPoint) begin
      cls = ClsPoint;
    end else if (symbol_i == ChExp) begin
      cls = ClsExpMark;
    end else begin
      cls = ClsOther;
    end
  end

  assign beat_o.cls = cls;
  assign beat_o.eos = end_of_string_i;

endmodule
`default_nettype wire

// ===== hw/rtl/dnv_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number validator queue
// Small first-in first-out buffer that decouples the classifier from the
// parser.
// ----------------------------------------------------------------------------
module dnv_queue import dnv_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  dnv_beat_t  push_beat_i,
  input  logic       pop_i,
  output dnv_beat_t  pop_beat_o,
  output dnv_qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dnv_beat_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

  assign pop_beat_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);

endmodule
`default_nettype wire

// ===== hw/rtl/dnv_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number validator back end
// Runs the parse phase machine on queued character classes and holds the
// verdict in an output register until it is taken.
// ----------------------------------------------------------------------------
module dnv_back import dnv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dnv_beat_t  beat_i,
  input  dnv_qstat_t qstat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_is_valid_o
);

  typedef enum logic [3:0] {
    PhLead,
    PhSign,
    PhInt,
    PhPoint,
    PhFrac,
    PhEMark,
    PhESign,
    PhExp,
    PhTrail,
    PhReject
  } phase_e;

  phase_e phase_q, phase_next;
  logic   out_valid_q;
  logic   is_valid_q;
  logic   accepting;
  logic   out_free;

  always_comb begin
    phase_next = PhReject;
    unique case (phase_q)
      PhLead: begin
        unique case (beat_i.cls)
          ClsSpace: phase_next = PhLead;
          ClsSign:  phase_next = PhSign;
          ClsDigit: phase_next = PhInt;
          ClsPoint: phase_next = PhPoint;
          default:  phase_next = PhReject;
        endcase
      end
      PhSign: begin
        unique case (beat_i.cls)
          ClsDigit: phase_next = PhInt;
          ClsPoint: phase_next = PhPoint;
          default:  phase_next = PhReject;
        endcase
      end
      PhInt: begin
        unique case (beat_i.cls)
          ClsDigit:   phase_next = PhInt;
          ClsPoint:   phase_next = PhPoint;
          ClsExpMark: phase_next = PhEMark;
          ClsSpace:   phase_next = PhTrail;
          default:    phase_next = PhReject;
        endcase
      end
      PhPoint: begin
        phase_next = (beat_i.cls == ClsDigit) ? PhFrac : PhReject;
      end
      PhFrac: begin
        unique case (beat_i.cls)
          ClsDigit:   phase_next = PhFrac;
          ClsExpMark: phase_next = PhEMark;
          ClsSpace:   phase_next = PhTrail;
          default:    phase_next = PhReject;
        endcase
      end
      PhEMark: begin
        unique case (beat_i.cls)
          ClsSign:  phase_next = PhESign;
          ClsDigit: phase_next = PhExp;
          default:  phase_next = PhReject;
        endcase
      end
      PhESign: begin
        phase_next = (beat_i.cls == ClsDigit) ? PhExp : PhReject;
      end
      PhExp: begin
        unique case (beat_i.cls)
          ClsDigit: phase_next = PhExp;
          ClsSpace: phase_next = PhTrail;
          default:  phase_next = PhReject;
        endcase
      end
      PhTrail: begin
        phase_next = (beat_i.cls == ClsSpace) ? PhTrail : PhReject;
      end
      default: phase_next = PhReject;
    endcase
  end

  assign accepting = (phase_next == PhInt) || (phase_next == PhFrac) ||
                     (phase_next == PhExp) || (phase_next == PhTrail);

  // A beat without end of string makes no result, so it may advance even
  // while a verdict waits downstream.
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !qstat_i.empty && (!beat_i.eos || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= beat_i.eos ? PhLead : phase_next;
      end
      if (pop_o && beat_i.eos) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && beat_i.eos) begin
      is_valid_q <= accepting;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_is_valid_o = is_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/decimal_number_validator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal number validator
// Checks a character stream, one byte per beat, and gives one verdict beat
// on the byte that ends each string.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained while the output is not stalled.
// Path: the edge that accepts the last byte of a string writes it into the queue,
// and the edge that pops it from the queue parses it into the output register,
// where the verdict then appears.
// The queue holds up to Depth beats, so the input stalls only once that many
// bytes have piled up behind a stalled verdict.
// Reset: asynchronous, active low; the queue empties, the parser returns to
// the leading blank phase and no verdict is pending.
// ----------------------------------------------------------------------------
module decimal_number_validator import dnv_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_symbol_i,
  input  logic       in_end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_is_valid_o
);

  dnv_beat_t  push_beat;
  dnv_beat_t  pop_beat;
  dnv_qstat_t qstat;
  logic       push;
  logic       pop;

  // The front end only classifies bytes; a beat is accepted whenever the
  // queue has room, independent of what the output side is doing.
  dnv_front u_front (
    .symbol_i        (in_symbol_i),
    .end_of_string_i (in_end_of_string_i),
    .beat_o          (push_beat)
  );

  assign in_stall_o = qstat.full;
  assign push       = in_valid_i && !qstat.full;

  dnv_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_beat_i (push_beat),
    .pop_i       (pop),
    .pop_beat_o  (pop_beat),
    .stat_o      (qstat)
  );

  // The back end steps the phase machine once per popped beat and registers
  // the verdict, which acts as the output stage.
  dnv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (pop_beat),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_is_valid_o (out_is_valid_o)
  );

  // The parser never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && qstat.empty))
    else $error("pop from empty queue");

  // Popping the last byte of a string always presents a verdict next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop && pop_beat.eos) |=> out_valid_o)
    else $error("end of string popped without a verdict");

  // A beat pushed without a pop leaves the queue non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !pop) |=> !qstat.empty)
    else $error("pushed beat lost");

  // A full and empty queue at once is a counter fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(qstat.full && qstat.empty))
    else $error("queue status inconsistent");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal number validator testbench
// Sends strings into the validator one byte per beat and keeps its own
// character-class parser in step with every accepted byte. Each verdict beat
// is compared with the verdict that the parser worked out for the string.
// The run starts with a short hand-picked set of strings. Random strings
// follow: mostly well-formed numbers, some of them mutated, and some noise.
// ----------------------------------------------------------------------------
module tb;
  import dnv_pkg::*;

  // The watchdog ends the run after this many cycles in which no beat moves
  // on either channel. The longest correct gap is the receiver hold-off below.
  localparam int unsigned StallLimit    = 5000;
  // Length of the receiver hold-off that makes the internal queue fill up.
  localparam int unsigned HoldCycles    = 60;
  // A verdict leaves through the queue and then the output register; this wait settles it.
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned BytesPerPhase = 530;
  localparam int unsigned ReportLimit   = 10;

  // Characters that the grammar cares about.
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChPoint  = 8'h2e;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChFive   = 8'h35;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperE = 8'h45;
  localparam logic [7:0] ChLowerE = 8'h65;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChAllOne = 8'hff;

  // Where the parser stands inside the current string.
  typedef enum logic [3:0] {
    PhLead,
    PhSign,
    PhInt,
    PhPoint,
    PhFrac,
    PhEMark,
    PhESign,
    PhExp,
    PhTrail,
    PhReject
  } parse_phase_e;

  // One byte waiting to be sent, with its end-of-string mark.
  typedef struct packed {
    logic [7:0] symbol;
    logic       eos;
  } char_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_symbol_i;
  logic       in_end_of_string_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       out_is_valid_o;

  char_beat_t   pending_chars[$];
  logic         expected_verdicts[$];
  parse_phase_e string_phase;
  logic         in_fire;
  int unsigned  chars_queued;
  int unsigned  chars_taken;
  int unsigned  error_count;
  int unsigned  quiet_cycles;
  int unsigned  src_gap_pct;
  int unsigned  sink_gap_pct;
  int unsigned  hold_request;
  int unsigned  hold_left;

  decimal_number_validator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_symbol_i        (in_symbol_i),
    .in_end_of_string_i (in_end_of_string_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_is_valid_o     (out_is_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Verdict prediction
  // --------------------------------------------------------------------------

  // Reduce a byte to the class the grammar sees. Only the lowercase e marks an
  // exponent; every other byte outside the listed ones, the zero byte too, is
  // an invalid character.
  function automatic sym_class_e classify_char(logic [7:0] ch);
    if (ch == ChSpace) return ClsSpace;
    if (ch == ChPlus || ch == ChMinus) return ClsSign;
    if (ch >= ChZero && ch <= ChNine) return ClsDigit;
    if (ch == ChPoint) return ClsPoint;
    if (ch == ChLowerE) return ClsExpMark;
    return ClsOther;
  endfunction

  // One step of the number grammar. Anything not listed for a phase drops the
  // string into the reject phase, which it never leaves before its end.
  function automatic parse_phase_e advance_phase(parse_phase_e ph, sym_class_e cls);
    case (ph)
      PhLead: begin
        if (cls == ClsSpace) return PhLead;
        if (cls == ClsSign) return PhSign;
        if (cls == ClsDigit) return PhInt;
        if (cls == ClsPoint) return PhPoint;
      end
      PhSign: begin
        if (cls == ClsDigit) return PhInt;
        if (cls == ClsPoint) return PhPoint;
      end
      PhInt: begin
        if (cls == ClsDigit) return PhInt;
        if (cls == ClsPoint) return PhPoint;
        if (cls == ClsExpMark) return PhEMark;
        if (cls == ClsSpace) return PhTrail;
      end
      PhPoint: begin
        if (cls == ClsDigit) return PhFrac;
      end
      PhFrac: begin
        if (cls == ClsDigit) return PhFrac;
        if (cls == ClsExpMark) return PhEMark;
        if (cls == ClsSpace) return PhTrail;
      end
      PhEMark: begin
        if (cls == ClsSign) return PhESign;
        if (cls == ClsDigit) return PhExp;
      end
      PhESign: begin
        if (cls == ClsDigit) return PhExp;
      end
      PhExp: begin
        if (cls == ClsDigit) return PhExp;
        if (cls == ClsSpace) return PhTrail;
      end
      PhTrail: begin
        if (cls == ClsSpace) return PhTrail;
      end
      default: ;
    endcase
    return PhReject;
  endfunction

  // A string is a number only if it stops after a digit or in trailing blanks.
  function automatic logic phase_accepts(parse_phase_e ph);
    return ph == PhInt || ph == PhFrac || ph == PhExp || ph == PhTrail;
  endfunction

  // Every byte accepted at a rising edge advances the parser. The byte that
  // ends a string yields the expected verdict, and the parser starts over at
  // the leading blanks so each string is judged on its own. in_fire tells the
  // driver at the next falling edge that its beat has gone.
  always @(posedge clk_i or negedge rst_ni) begin : predict
    parse_phase_e nxt;
    if (!rst_ni) begin
      in_fire      <= 1'b0;
      string_phase <= PhLead;
      chars_taken  <= 0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        chars_taken <= chars_taken + 1;
        nxt = advance_phase(string_phase, classify_char(in_symbol_i));
        if (in_end_of_string_i) begin
          expected_verdicts.push_back(phase_accepts(nxt));
          string_phase <= PhLead;
        end else begin
          string_phase <= nxt;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic want, logic got);
    error_count++;
    if (error_count <= ReportLimit) begin
      $display("%0t: %s: expected is_valid %b, got %b", $realtime, what, want, got);
    end
  endtask

  // A verdict beat is taken at a rising edge with valid high and stall low,
  // and is matched against the oldest verdict still waiting.
  always @(posedge clk_i) begin : check_verdict
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("verdict beat with no string ended", 1'bx, out_is_valid_o);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_is_valid_o !== want) begin
          report_mismatch("wrong verdict", want, out_is_valid_o);
        end
      end
    end
  end

  // The watchdog counts cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // The sender moves on at a falling edge only once its beat has been taken,
  // or when nothing is offered. While stalled the beat stays as it is. Valid
  // is decided from the queue and the gap rate alone, never from the stall.
  always @(negedge clk_i) begin : drive_chars
    char_beat_t nb;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        nb = pending_chars.pop_front();
        in_valid_i         <= 1'b1;
        in_symbol_i        <= nb.symbol;
        in_end_of_string_i <= nb.eos;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, or for a long hold-off when one is asked
  // for. The hold-off is counted here, in cycles, while the sender carries on,
  // so the queue inside the block fills and the block stalls its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left    = hold_left - 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_gap_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic queue_char(logic [7:0] ch, logic eos);
    char_beat_t nb;
    nb.symbol = ch;
    nb.eos    = eos;
    pending_chars.push_back(nb);
    chars_queued++;
  endtask

  task automatic queue_string(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) begin
      queue_char(s[i], i == s.size() - 1);
    end
  endtask

  function automatic logic [7:0] random_digit();
    return 8'(ChZero + $urandom_range(9));
  endfunction

  // A byte that is likely to matter to the grammar, now and then any byte.
  function automatic logic [7:0] awkward_char();
    case ($urandom_range(7))
      0: return ChSpace;
      1: return ChPlus;
      2: return ChMinus;
      3: return ChPoint;
      4: return ChLowerE;
      5: return ChUpperE;
      6: return random_digit();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Most strings are well-formed numbers with random content, so that every
  // phase of the grammar is reached. Some get one byte replaced, inserted or
  // dropped, and a few are plain noise over the whole byte range.
  task automatic queue_random_string();
    logic [7:0]  s[$];
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    kind = $urandom_range(99);
    if (kind < 88) begin
      repeat ($urandom_range(2)) s.push_back(ChSpace);
      if ($urandom_range(2) == 0) s.push_back($urandom_range(1) ? ChPlus : ChMinus);
      n = $urandom_range(3);
      repeat (n) s.push_back(random_digit());
      if (n == 0 || $urandom_range(1)) begin
        s.push_back(ChPoint);
        repeat (n == 0 ? 1 + $urandom_range(2) : $urandom_range(3)) begin
          s.push_back(random_digit());
        end
      end
      if ($urandom_range(2) == 0) begin
        s.push_back(ChLowerE);
        if ($urandom_range(1)) s.push_back($urandom_range(1) ? ChPlus : ChMinus);
        repeat (1 + $urandom_range(2)) s.push_back(random_digit());
      end
      repeat ($urandom_range(2)) s.push_back(ChSpace);
      if (kind >= 70) begin
        pos = $urandom_range(s.size() - 1);
        case ($urandom_range(2))
          0: s[pos] = awkward_char();
          1: s.insert(pos, awkward_char());
          default: if (s.size() > 1) s.delete(pos);
        endcase
      end
    end else begin
      repeat (1 + $urandom_range(3)) s.push_back(8'($urandom_range(255)));
    end
    queue_string(s);
  endtask

  // The sender waits until every byte has gone in and every verdict has come
  // out, then lets the last verdict settle.
  task automatic wait_until_drained();
    while (!(chars_taken == chars_queued && expected_verdicts.size() == 0 &&
             pending_chars.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    in_symbol_i        = 8'h00;
    in_end_of_string_i = 1'b0;
    out_stall_i        = 1'b0;
    chars_queued       = 0;
    error_count        = 0;
    quiet_cycles       = 0;
    src_gap_pct        = 0;
    sink_gap_pct       = 0;
    hold_request       = 0;
    hold_left          = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Three rounds of idling: a slow receiver, then a slow sender, then
    // neither. Each round ends with the sender pausing until all is drained.
    for (int round = 0; round < 3; round++) begin
      case (round)
        0: begin
          src_gap_pct  = 17;
          sink_gap_pct = 62;
        end
        1: begin
          src_gap_pct  = 62;
          sink_gap_pct = 17;
        end
        default: begin
          src_gap_pct  = 0;
          sink_gap_pct = 0;
        end
      endcase

      if (round == 0) begin
        // A sign, point, fraction, exponent sign and trailing blank; no integer digits.
        queue_string('{ChMinus, ChPoint, ChFive, ChLowerE, ChPlus, ChNine, ChSpace});
        // Leading blank before a single digit.
        queue_string('{ChSpace, ChSeven});
        // A lone point, a trailing point, and a point just before the exponent.
        queue_string('{ChPoint});
        queue_string('{ChFive, ChPoint});
        queue_string('{ChFive, ChPoint, ChLowerE, ChOne});
        // A second point in the mantissa.
        queue_string('{ChOne, ChPoint, ChPoint});
        // Uppercase exponent mark is not allowed.
        queue_string('{ChOne, ChUpperE});
        // A string of blanks only.
        queue_string('{ChSpace});
        // The zero byte is an ordinary bad character, not an end of string.
        queue_string('{ChZero, ChNul});
        // Top byte on its own, then the smallest and largest digit.
        queue_string('{ChAllOne});
        queue_string('{ChZero});
        queue_string('{ChNine});
      end

      while (chars_queued < (round + 1) * BytesPerPhase) queue_random_string();

      // With no idling the sender offers bytes back to back while the
      // receiver holds off, so the block has to stall its input.
      if (round == 2) hold_request = HoldCycles;

      wait_until_drained();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== decimal_number_validator.f =====
hw/rtl/dnv_pkg.sv
hw/rtl/dnv_front.sv
hw/rtl/dnv_queue.sv
hw/rtl/dnv_back.sv
hw/rtl/decimal_number_validator.sv
test/tb.sv
